// ===== design/bips_pkg.sv =====
// Shared types, constants and helper functions of the interval poll scheduler.
// Used by the channel interfaces, the controller, the datapath and the top level.
package bips_pkg;

	localparam int SLOTS       = 16;
	localparam int GROUPS      = 16;
	localparam int MAX_RESULTS = 16;

	localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int GRP_W    = $clog2(GROUPS);
	localparam int NFIRE_W  = $clog2(MAX_RESULTS + 1);
	localparam int MODE_W   = 2;
	localparam int INTV_W   = 31;
	localparam int HANDLE_W = 4;
	localparam int STATUS_W = 2;
	localparam int PERIOD_W = 16;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK,
		MODE_ADD,
		MODE_CHANGE,
		MODE_DELETE
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FIRED,
		ST_DONE,
		ST_FULL,
		ST_UNUSED
	} status_t;

	typedef struct packed {
		logic idle;
		logic advance;
		logic decode;
		logic walk_clr;
		logic fire;
		logic flush;
		logic reeval;
		logic set_step;
		logic respond;
	} bips_cmd_t;

	typedef struct packed {
		logic  req_valid;
		mode_t mode;
		logic  any_used;
		logic  go;
		logic  walk_last;
		logic  stall;
		logic  hold_v;
		logic  out_free;
	} bips_sts_t;

	function automatic logic [GRP_W-1:0] group_of(input logic [INTV_W-1:0] v);
		int g;
		g = 0;
		for (int i = 1; i < INTV_W; i++) begin
			if (v[i]) begin
				g = i;
			end
		end
		if (g > GROUPS - 1) begin
			g = GROUPS - 1;
		end
		return GRP_W'(g);
	endfunction

	function automatic logic [PERIOD_W-1:0] period_of(input logic [GRP_W-1:0] g);
		return PERIOD_W'(1) << g;
	endfunction

endpackage

// ===== design/bips_if.sv =====
// Valid/ready channel interfaces for request and result items.
// Depends on bips_pkg for field widths.
interface bips_req_if;
	import bips_pkg::*;
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [INTV_W-1:0]   interval;
	logic [HANDLE_W-1:0] handle;

	modport source (output valid, output mode, output interval, output handle, input ready);
	modport sink (input valid, input mode, input interval, input handle, output ready);
endinterface

interface bips_rsp_if;
	import bips_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] handle_out;
	logic [PERIOD_W-1:0] interval_out;
	logic                last;

	modport source (output valid, output status, output handle_out, output interval_out,
		output last, input ready);
	modport sink (input valid, input status, input handle_out, input interval_out,
		input last, output ready);
endinterface

// ===== design/binary_interval_poll_scheduler_unit.sv =====
// Top level of the binary interval poll scheduler: controller plus datapath.
// Tick: decode, then the one-slot-per-cycle fire walk, which stalls while the output register
// is busy, then a flush of the held firing; a tick on an empty table ends after decode.
// Add, change, delete: decode, slot walk, step update, result; a refused one skips walk and step.
// One request in flight at a time; a held result never blocks accepting the next request.
// Reset clears slot use, group counters, step and handshake state at once.
module binary_interval_poll_scheduler_unit (
	input logic        clk,
	input logic        arst_n,
	bips_req_if.sink   req,
	bips_rsp_if.source rsp
);
	import bips_pkg::*;

	bips_cmd_t cmd;
	bips_sts_t sts;

	bips_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	bips_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ===== design/bips_ctrl.sv =====
// Controller state machine of the poll scheduler: sequences decode, slot walks and results.
// Depends on bips_pkg; drives the datapath bips_dp through command and status structs.
module bips_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bips_pkg::bips_sts_t  sts,
	output bips_pkg::bips_cmd_t  cmd
);
	import bips_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_FIRE,
		S_FLUSH,
		S_REEVAL,
		S_SETSTEP,
		S_RESP
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
			end
			S_DECODE: begin
				if (sts.mode == MODE_TICK) begin
					cmd.advance  = sts.any_used;
					cmd.walk_clr = sts.any_used;
				end else begin
					cmd.decode   = 1'b1;
					cmd.walk_clr = sts.go;
				end
			end
			S_FIRE: begin
				cmd.fire = !sts.stall;
			end
			S_FLUSH: begin
				cmd.flush = sts.hold_v && sts.out_free;
			end
			S_REEVAL: begin
				cmd.reeval = 1'b1;
			end
			S_SETSTEP: begin
				cmd.set_step = 1'b1;
			end
			S_RESP: begin
				cmd.respond = sts.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sts.req_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (sts.mode == MODE_TICK) begin
						state_q <= sts.any_used ? S_FIRE : S_IDLE;
					end else begin
						state_q <= sts.go ? S_REEVAL : S_RESP;
					end
				end
				S_FIRE: begin
					if (!sts.stall && sts.walk_last) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (!sts.hold_v || sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_REEVAL: begin
					if (sts.walk_last) begin
						state_q <= S_SETSTEP;
					end
				end
				S_SETSTEP: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.respond || cmd.flush) |-> sts.out_free)
		else $error("result loaded while output register busy");
	a_fire_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fire |-> !sts.stall)
		else $error("walk advanced over a stalled firing");
	a_empty_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECODE && sts.mode == MODE_TICK && !sts.any_used) |=> state_q == S_IDLE)
		else $error("tick on empty table not dropped");
`endif

endmodule

// ===== design/bips_dp.sv =====
// Datapath of the poll scheduler: slot table, group counters, step, walk index and result register.
// Depends on bips_pkg and the bips_req_if / bips_rsp_if channels; commanded by bips_ctrl.
module bips_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bips_pkg::bips_cmd_t  cmd,
	output bips_pkg::bips_sts_t  sts,
	bips_req_if.sink             req,
	bips_rsp_if.source           rsp
);
	import bips_pkg::*;

	logic [SLOTS-1:0]    used_q;
	logic [GRP_W-1:0]    grp_q [SLOTS];
	logic [PERIOD_W-1:0] cnt_q [GROUPS];
	logic [PERIOD_W-1:0] cnt_next [GROUPS];
	logic [PERIOD_W-1:0] step_q;

	mode_t               mode_q;
	logic [GRP_W-1:0]    newgrp_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [SLOT_W-1:0]   idx_q;
	logic                full_q;
	logic                ok_q;
	logic [GRP_W:0]      min_q;

	logic                hold_v_q;
	logic [NFIRE_W-1:0]  nfire_q;
	logic [SLOT_W-1:0]   hold_idx_q;
	logic [GRP_W-1:0]    hold_grp_q;

	status_t             res_status_q;
	logic [HANDLE_W-1:0] res_handle_q;
	logic [PERIOD_W-1:0] res_intv_q;

	logic                rsp_valid_q;
	status_t             rsp_status_q;
	logic [HANDLE_W-1:0] rsp_handle_q;
	logic [PERIOD_W-1:0] rsp_intv_q;
	logic                rsp_last_q;

	logic                accept;
	logic                full;
	logic [SLOT_W-1:0]   free_idx;
	logic [SLOT_W-1:0]   handle_idx;
	logic                handle_in;
	logic [GRP_W-1:0]    cur_grp;
	logic                cur_used;
	logic [PERIOD_W-1:0] cur_cnt;
	logic                hit;
	logic                out_free;
	logic                go;
	logic                rsp_load;

	assign accept     = cmd.idle && req.valid;
	assign req.ready  = cmd.idle;
	assign handle_idx = SLOT_W'(req.handle);
	assign handle_in  = int'(req.handle) < SLOTS;
	assign cur_grp    = grp_q[idx_q];
	assign cur_used   = used_q[idx_q];
	assign cur_cnt    = cnt_q[cur_grp];
	assign hit        = cur_used && (cur_cnt == '0) && (nfire_q < NFIRE_W'(MAX_RESULTS));
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign go         = (mode_q == MODE_ADD) ? !full_q : ok_q;
	assign rsp_load   = (cmd.fire && hit && hold_v_q) || cmd.flush || cmd.respond;

	always_comb begin
		full     = 1'b1;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				full     = 1'b0;
				free_idx = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		logic [PERIOD_W:0] sum;
		for (int i = 0; i < GROUPS; i++) begin
			sum = {1'b0, cnt_q[i]} + {1'b0, step_q};
			if (sum >= {1'b0, period_of(GRP_W'(i))}) begin
				cnt_next[i] = '0;
			end else begin
				cnt_next[i] = sum[PERIOD_W-1:0];
			end
		end
	end

	always_comb begin
		sts.req_valid = req.valid;
		sts.mode      = mode_q;
		sts.any_used  = |used_q;
		sts.go        = go;
		sts.walk_last = idx_q == SLOT_W'(SLOTS - 1);
		sts.stall     = hit && hold_v_q && !out_free;
		sts.hold_v    = hold_v_q;
		sts.out_free  = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
			hold_v_q    <= 1'b0;
			nfire_q     <= '0;
			for (int i = 0; i < GROUPS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cmd.decode && go) begin
				unique case (mode_q)
					MODE_ADD:    used_q[idx_q] <= 1'b1;
					MODE_DELETE: used_q[idx_q] <= 1'b0;
					MODE_TICK, MODE_CHANGE: begin
					end
				endcase
			end
			if (cmd.advance) begin
				for (int i = 0; i < GROUPS; i++) begin
					cnt_q[i] <= cnt_next[i];
				end
			end
			if (cmd.set_step && (min_q < (GRP_W + 1)'(GROUPS))) begin
				step_q <= period_of(min_q[GRP_W-1:0]);
			end
			if (cmd.walk_clr) begin
				hold_v_q <= 1'b0;
				nfire_q  <= '0;
			end
			if (cmd.fire && hit) begin
				hold_v_q <= 1'b1;
				nfire_q  <= nfire_q + NFIRE_W'(1);
			end
			if (cmd.flush) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode_t'(req.mode);
			newgrp_q <= group_of(req.interval);
			handle_q <= req.handle;
			idx_q    <= (mode_t'(req.mode) == MODE_ADD) ? free_idx : handle_idx;
			full_q   <= full;
			ok_q     <= handle_in && used_q[handle_idx];
		end
		if (cmd.decode) begin
			if (go && (mode_q == MODE_ADD || mode_q == MODE_CHANGE)) begin
				grp_q[idx_q] <= newgrp_q;
			end
			unique case (mode_q)
				MODE_ADD: begin
					res_status_q <= full_q ? ST_FULL : ST_DONE;
					res_handle_q <= full_q ? '0 : HANDLE_W'(idx_q);
					res_intv_q   <= full_q ? '0 : period_of(newgrp_q);
				end
				MODE_CHANGE: begin
					res_status_q <= ok_q ? ST_DONE : ST_UNUSED;
					res_handle_q <= handle_q;
					res_intv_q   <= ok_q ? period_of(newgrp_q) : '0;
				end
				MODE_DELETE: begin
					res_status_q <= ok_q ? ST_DONE : ST_UNUSED;
					res_handle_q <= handle_q;
					res_intv_q   <= ok_q ? period_of(cur_grp) : '0;
				end
				MODE_TICK: begin
				end
			endcase
		end
		if (cmd.walk_clr) begin
			idx_q <= '0;
			min_q <= (GRP_W + 1)'(GROUPS);
		end
		if (cmd.reeval) begin
			if (cur_used && ({1'b0, cur_grp} < min_q)) begin
				min_q <= {1'b0, cur_grp};
			end
			idx_q <= idx_q + SLOT_W'(1);
		end
		if (cmd.fire) begin
			idx_q <= idx_q + SLOT_W'(1);
			if (hit) begin
				hold_idx_q <= idx_q;
				hold_grp_q <= cur_grp;
				if (hold_v_q) begin
					rsp_status_q <= ST_FIRED;
					rsp_handle_q <= HANDLE_W'(hold_idx_q);
					rsp_intv_q   <= period_of(hold_grp_q);
					rsp_last_q   <= 1'b0;
				end
			end
		end
		if (cmd.flush) begin
			rsp_status_q <= ST_FIRED;
			rsp_handle_q <= HANDLE_W'(hold_idx_q);
			rsp_intv_q   <= period_of(hold_grp_q);
			rsp_last_q   <= 1'b1;
		end
		if (cmd.respond) begin
			rsp_status_q <= res_status_q;
			rsp_handle_q <= res_handle_q;
			rsp_intv_q   <= res_intv_q;
			rsp_last_q   <= 1'b1;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.handle_out   = rsp_handle_q;
	assign rsp.interval_out = rsp_intv_q;
	assign rsp.last         = rsp_last_q;

`ifndef NO_ASSERTIONS
	a_hold_counted: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> nfire_q != '0)
		else $error("held firing not counted");
	a_step_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.set_step && (min_q < (GRP_W + 1)'(GROUPS))) |=> $onehot(step_q))
		else $error("step is not a power of two");
	a_group0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |=> cnt_q[0] == '0)
		else $error("unit period counter not at zero after tick");
`endif

endmodule
